/* rtl/core/assert_macros.svh */
// Assertion macros for the RTL files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked while out of reset.
`define SCPD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
// Next-cycle implication, checked while out of reset.
`define SCPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`else
`define SCPD_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SCPD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/core/scpd_pkg.sv */
// Shared types and constants of the checksum packet deframer.
package scpd_pkg;

    // Payload bytes per packet, 1 to 8.
    localparam int PAYLOAD_BYTES = 8;
    localparam int CNT_W         = $clog2(PAYLOAD_BYTES + 1);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_HEADER_VALUE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ID_BASE        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ID_ENABLE_MASK = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHECK_ENABLE   = 2'd3;

    localparam logic [7:0]  HEADER_VALUE_RST   = 8'd85;
    localparam logic [7:0]  ID_BASE_RST        = 8'd80;
    localparam logic [15:0] ID_ENABLE_MASK_RST = 16'd2047;
    localparam logic        CHECK_ENABLE_RST   = 1'b0;

    typedef struct packed {
        logic [7:0]  header_value;
        logic [7:0]  id_base;
        logic [15:0] id_enable_mask;
        logic        check_enable;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  packet_id;
        logic [63:0] payload;
        logic [7:0]  checksum_byte;
        logic        checksum_ok;
    } result_t;

endpackage

/* rtl/core/sum_checked_packet_deframer_unit.sv */
// Sum-checked packet deframer: one received byte in per cycle, at most one packet
// out per checksum byte. Each request on the rx channel is one byte; a byte is
// taken into an input register and handled by the framing logic once the result
// register can take a result; a packet leaves through the result register. The
// sustained rate is one byte per clock, set by the framer step between the
// input register and the result register; it drops only while a finished packet
// waits in the result register with pkt_ready low. Configuration writes take
// effect in the cycle after the request and must be issued only while no byte
// is in flight.
`include "assert_macros.svh"

module sum_checked_packet_deframer_unit
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [scpd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [scpd_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             rx_valid,
    output logic                             rx_ready,
    input  logic [7:0]                       rx_byte,
    output logic                             pkt_valid,
    input  logic                             pkt_ready,
    output logic [7:0]                       packet_id,
    output logic [63:0]                      payload,
    output logic [7:0]                       checksum_byte,
    output logic                             checksum_ok
);

    scpd_pkg::cfg_t     cfg;
    scpd_pkg::result_t  res;
    logic               can_step;
    logic               step;
    logic               in_valid_reg;
    logic               in_valid_next;
    logic [7:0]         in_byte_reg;

    scpd_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign step          = in_valid_reg && can_step;
    assign rx_ready      = !in_valid_reg || can_step;
    assign in_valid_next = (rx_valid && rx_ready) || (in_valid_reg && !can_step);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (rx_valid && rx_ready)
            begin
                in_byte_reg <= rx_byte;
            end
        end
    end

    scpd_framer u_framer
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .step      (step),
        .step_byte (in_byte_reg),
        .can_step  (can_step),
        .res_valid (pkt_valid),
        .res_ready (pkt_ready),
        .res       (res)
    );

    assign packet_id     = res.packet_id;
    assign payload       = res.payload;
    assign checksum_byte = res.checksum_byte;
    assign checksum_ok   = res.checksum_ok;

    // A new packet only ever follows a framer step.
    `SCPD_ASSERT_NOW(a_pkt_from_step, clk, rst_n, $rose(pkt_valid), $past(step))
    // A held byte is never overwritten before the framer consumes it.
    `SCPD_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid_reg && !step,
                      in_valid_reg && $stable(in_byte_reg))
    // With checking on, a bad checksum never leaves the block.
    `SCPD_ASSERT_NOW(a_check_drop, clk, rst_n, pkt_valid && cfg.check_enable, checksum_ok)

endmodule

/* rtl/core/scpd_cfg_regs.sv */
// Configuration register file of the checksum packet deframer.
module scpd_cfg_regs
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [scpd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [scpd_pkg::CFG_DATA_W-1:0]  cfg_data,
    output scpd_pkg::cfg_t                   cfg
);

    scpd_pkg::cfg_t cfg_reg;
    scpd_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                scpd_pkg::REG_HEADER_VALUE:   cfg_next.header_value   = cfg_data[7:0];
                scpd_pkg::REG_ID_BASE:        cfg_next.id_base        = cfg_data[7:0];
                scpd_pkg::REG_ID_ENABLE_MASK: cfg_next.id_enable_mask = cfg_data[15:0];
                scpd_pkg::REG_CHECK_ENABLE:   cfg_next.check_enable   = cfg_data[0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_value   <= scpd_pkg::HEADER_VALUE_RST;
            cfg_reg.id_base        <= scpd_pkg::ID_BASE_RST;
            cfg_reg.id_enable_mask <= scpd_pkg::ID_ENABLE_MASK_RST;
            cfg_reg.check_enable   <= scpd_pkg::CHECK_ENABLE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* rtl/core/scpd_framer.sv */
// Framing state machine, running checksum, payload store and result register.
module scpd_framer
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  scpd_pkg::cfg_t         cfg,
    input  logic                   step,
    input  logic [7:0]             step_byte,
    output logic                   can_step,
    output logic                   res_valid,
    input  logic                   res_ready,
    output scpd_pkg::result_t      res
);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_ID,
        PH_DATA
    } phase_t;

    phase_t                         phase_reg;
    phase_t                         phase_next;
    logic [scpd_pkg::CNT_W-1:0]     byte_index_reg;
    logic [scpd_pkg::CNT_W-1:0]     byte_index_next;
    logic [7:0]                     current_id_reg;
    logic [7:0]                     current_id_next;
    logic [7:0]                     running_sum_reg;
    logic [7:0]                     running_sum_next;
    logic [7:0]                     payload_store [scpd_pkg::PAYLOAD_BYTES];
    logic                           res_valid_reg;
    logic                           res_valid_next;
    scpd_pkg::result_t              res_reg;
    scpd_pkg::result_t              res_next;

    logic [8:0]                     id_offset;
    logic                           id_ok;
    logic                           last_byte;
    logic                           sum_ok;
    logic                           store_wr;
    logic [63:0]                    payload_flat;

    // The result register can take a new result when empty or being drained.
    assign can_step  = !res_valid_reg || res_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign id_offset = {1'b0, step_byte} - {1'b0, cfg.id_base};
    // No wrap: the offset borrows when the ID lies below the base.
    assign id_ok     = !id_offset[8] && (id_offset[7:4] == 4'd0)
                       && cfg.id_enable_mask[id_offset[3:0]];
    assign last_byte = (byte_index_reg == scpd_pkg::CNT_W'(scpd_pkg::PAYLOAD_BYTES));
    assign sum_ok    = (running_sum_reg == step_byte);

    always_comb
    begin
        payload_flat = '0;
        for (int i = 0; i < scpd_pkg::PAYLOAD_BYTES; i++)
        begin
            payload_flat[8*i +: 8] = payload_store[i];
        end
    end

    always_comb
    begin
        phase_next       = phase_reg;
        byte_index_next  = byte_index_reg;
        current_id_next  = current_id_reg;
        running_sum_next = running_sum_reg;
        store_wr         = 1'b0;
        res_valid_next   = res_valid_reg && !res_ready;
        res_next         = res_reg;

        if (step)
        begin
            unique case (phase_reg)
                PH_ID:
                begin
                    if (id_ok)
                    begin
                        current_id_next  = step_byte;
                        byte_index_next  = '0;
                        running_sum_next = cfg.header_value + step_byte;
                        phase_next       = PH_DATA;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_DATA:
                begin
                    if (last_byte)
                    begin
                        phase_next = PH_HUNT;
                        if (!cfg.check_enable || sum_ok)
                        begin
                            res_valid_next         = 1'b1;
                            res_next.packet_id     = current_id_reg;
                            res_next.payload       = payload_flat;
                            res_next.checksum_byte = step_byte;
                            res_next.checksum_ok   = sum_ok;
                        end
                    end
                    else
                    begin
                        store_wr         = 1'b1;
                        running_sum_next = running_sum_reg + step_byte;
                        byte_index_next  = byte_index_reg + scpd_pkg::CNT_W'(1);
                    end
                end
                default:
                begin
                    phase_next = (step_byte == cfg.header_value) ? PH_ID : PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HUNT;
            byte_index_reg  <= '0;
            current_id_reg  <= '0;
            running_sum_reg <= '0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            byte_index_reg  <= byte_index_next;
            current_id_reg  <= current_id_next;
            running_sum_reg <= running_sum_next;
            res_valid_reg   <= res_valid_next;
            res_reg         <= res_next;
            for (int i = 0; i < scpd_pkg::PAYLOAD_BYTES; i++)
            begin
                if (store_wr && (byte_index_reg == scpd_pkg::CNT_W'(i)))
                begin
                    payload_store[i] <= step_byte;
                end
            end
        end
    end

endmodule
